>>> src/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// shared types and constants of the string escape decoder
// ----------------------------------------------------------------------------
package scd_pkg;

  // most results one input byte can cause (four utf-8 bytes and the status)
  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  typedef enum logic [2:0] {
    M_OPEN = 3'd0,
    M_BODY = 3'd1,
    M_ESC  = 3'd2,
    M_OCT  = 3'd3,
    M_HEX  = 3'd4,
    M_U4   = 3'd5,
    M_U8   = 3'd6,
    M_DONE = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_END_QUOTE = 3'd1,
    ST_OCT_RANGE = 3'd2,
    ST_HEX_RANGE = 3'd3,
    ST_HEX_DIG   = 3'd4,
    ST_UNI_RANGE = 3'd5,
    ST_BAD_ESC   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    status_t    code;
  } res_ent_t;

  // all results of one input byte, in delivery order
  typedef struct packed {
    res_ent_t [MAX_RES-1:0] ents;
    logic [CNT_W-1:0]       cnt;
  } res_set_t;

endpackage

>>> src/scd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_in_if / scd_out_if
// valid/ready channels for token bytes and decoded results
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       token_end;

  modport source(output valid, output char_byte, output token_end, input ready);
  modport sink(input valid, input char_byte, input token_end, output ready);
endinterface

interface scd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_status;
  logic [2:0] status_code;
  logic       last;

  modport source(output valid, output out_byte, output is_status,
                 output status_code, output last, input ready);
  modport sink(input valid, input out_byte, input is_status,
               input status_code, input last, output ready);
endinterface

>>> src/string_literal_escape_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_core
// decodes the bytes of a quoted string-literal token into literal bytes
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      role
//  token    in   char_byte[8], token_end                      token text bytes
//  result   out  out_byte[8], is_status, status_code[3], last decoded bytes
//
//  one byte per cycle while results are taken; a byte with several results
//  holds the input until its last result is taken; a byte passes the input
//  register, then the registered result set on the output side, so a stalled
//  result still lets one further byte wait in the input register
//  rst (synchronous) clears the parse state and drops pending results
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_core
  import scd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  scd_in_if.sink    token,
  scd_out_if.source result
);

  // input register
  logic       in_v;
  logic [7:0] in_byte;
  logic       in_end;

  // result buffer can take a new set this cycle
  logic       free;
  logic       step;
  res_set_t   set;

  assign step        = in_v && free;
  assign token.ready = !in_v || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (token.valid && token.ready) begin
      in_v <= 1'b1;
    end else if (step) begin
      in_v <= 1'b0;
    end
  end

  // payload only loads with a request
  always_ff @(posedge clk) begin
    if (token.valid && token.ready) begin
      in_byte <= token.char_byte;
      in_end  <= token.token_end;
    end
  end

  // parse state plus one-pass decode of the held byte
  scd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_byte (in_byte),
    .token_end (in_end),
    .res       (set)
  );

  // results leave one per cycle while the receiver is ready
  scd_result_buf u_res (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .set    (set),
    .free   (free),
    .result (result)
  );

`ifndef SYNTHESIS
  // status closes the results of its byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_status |-> result.last)
    else $error("status result not marked last");
  // data results carry no status code
  a_data_code: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.is_status |-> (result.status_code == ST_OK))
    else $error("status code on data result");
  // a waiting byte stays put until decoded
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_v && !free |=> in_v && $stable(in_byte) && $stable(in_end))
    else $error("held input byte lost");
`endif

endmodule

>>> src/scd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_parser
// escape parse state and single-pass decode of one byte into its results
// ----------------------------------------------------------------------------
module scd_parser
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_byte,
  input  logic       token_end,
  output res_set_t   res
);

  mode_t       mode, mode_next;
  logic [31:0] digit_value, digit_value_next;
  logic [3:0]  digit_count, digit_count_next;
  logic        value_overflow, value_overflow_next;
  status_t     first_error, first_error_next;

  logic        is_oct;
  logic        hex_ok;
  logic [3:0]  hex_v;

  always_comb begin
    is_oct = (char_byte >= 8'h30) && (char_byte <= 8'h37);
    hex_ok = 1'b1;
    hex_v  = '0;
    if ((char_byte >= 8'h30) && (char_byte <= 8'h39)) begin
      hex_v = char_byte[3:0];
    end else if ((char_byte >= 8'h61) && (char_byte <= 8'h66)) begin
      hex_v = char_byte[3:0] + 4'd9;
    end else if ((char_byte >= 8'h41) && (char_byte <= 8'h46)) begin
      hex_v = char_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] n;
    res_ent_t [MAX_RES-1:0] ents;
    logic        do_body;
    logic [31:0] acc;
    logic [31:0] v;

    mode_next           = mode;
    digit_value_next    = digit_value;
    digit_count_next    = digit_count;
    value_overflow_next = value_overflow;
    first_error_next    = first_error;
    n       = '0;
    ents    = '0;
    do_body = 1'b0;
    acc     = '0;
    v       = '0;

    unique case (mode)
      M_OPEN: mode_next = M_BODY;
      M_BODY: do_body = 1'b1;
      M_ESC: begin
        mode_next = M_BODY;
        if (is_oct) begin
          mode_next           = M_OCT;
          digit_value_next    = {29'd0, char_byte[2:0]};
          digit_count_next    = 4'd1;
          value_overflow_next = 1'b0;
        end else begin
          unique case (char_byte)
            8'h22, 8'h27, 8'h5c: begin
              ents[n[IDX_W-1:0]].data = char_byte; n = n + 1'b1;
            end
            8'h61: begin ents[n[IDX_W-1:0]].data = 8'd7;  n = n + 1'b1; end
            8'h62: begin ents[n[IDX_W-1:0]].data = 8'd8;  n = n + 1'b1; end
            8'h66: begin ents[n[IDX_W-1:0]].data = 8'd12; n = n + 1'b1; end
            8'h6e: begin ents[n[IDX_W-1:0]].data = 8'd10; n = n + 1'b1; end
            8'h72: begin ents[n[IDX_W-1:0]].data = 8'd13; n = n + 1'b1; end
            8'h74: begin ents[n[IDX_W-1:0]].data = 8'd9;  n = n + 1'b1; end
            8'h76: begin ents[n[IDX_W-1:0]].data = 8'd11; n = n + 1'b1; end
            8'h78, 8'h75, 8'h55: begin
              mode_next = (char_byte == 8'h78) ? M_HEX :
                          (char_byte == 8'h75) ? M_U4 : M_U8;
              digit_value_next    = '0;
              digit_count_next    = '0;
              value_overflow_next = 1'b0;
            end
            default: begin
              if (first_error_next == ST_OK) first_error_next = ST_BAD_ESC;
              mode_next = M_DONE;
            end
          endcase
        end
      end
      M_OCT: begin
        if (is_oct) begin
          digit_value_next = {digit_value[28:0], char_byte[2:0]};
          digit_count_next = digit_count + 4'd1;
        end else begin
          do_body = 1'b1;
        end
        if (!is_oct || (digit_count_next >= 4'd3)) begin
          if (digit_value_next <= 32'd255) begin
            ents[n[IDX_W-1:0]].data = digit_value_next[7:0]; n = n + 1'b1;
            mode_next = M_BODY;
          end else begin
            if (first_error_next == ST_OK) first_error_next = ST_OCT_RANGE;
            mode_next = M_DONE;
          end
        end
      end
      M_HEX: begin
        if (hex_ok) begin
          acc = {digit_value[27:0], hex_v};
          if (acc > 32'd255) begin
            value_overflow_next = 1'b1;
            digit_value_next    = 32'd256;
          end else begin
            digit_value_next = acc;
          end
          if (digit_count < 4'd15) digit_count_next = digit_count + 4'd1;
        end else begin
          do_body = 1'b1;
          if (digit_count_next == 4'd0) begin
            if (first_error_next == ST_OK) first_error_next = ST_HEX_DIG;
            mode_next = M_DONE;
          end else if (value_overflow_next) begin
            if (first_error_next == ST_OK) first_error_next = ST_HEX_RANGE;
            mode_next = M_DONE;
          end else begin
            ents[n[IDX_W-1:0]].data = digit_value_next[7:0]; n = n + 1'b1;
            mode_next = M_BODY;
          end
        end
      end
      M_U4, M_U8: begin
        if (hex_ok) begin
          digit_value_next = {digit_value[27:0], hex_v};
          digit_count_next = digit_count + 4'd1;
          if (digit_count_next >= ((mode == M_U4) ? 4'd4 : 4'd8)) begin
            v = digit_value_next;
            if (v[31]) begin
              if (first_error_next == ST_OK) first_error_next = ST_HEX_RANGE;
              mode_next = M_DONE;
            end else if (((v >= 32'h0000_D800) && (v <= 32'h0000_DFFF)) ||
                         (v >= 32'h0011_0000)) begin
              if (first_error_next == ST_OK) first_error_next = ST_UNI_RANGE;
              mode_next = M_DONE;
            end else begin
              // utf-8 encoding, one to four bytes
              if (v < 32'h80) begin
                ents[0].data = v[7:0];
                n = 3'd1;
              end else if (v < 32'h800) begin
                ents[0].data = {3'b110, v[10:6]};
                ents[1].data = {2'b10, v[5:0]};
                n = 3'd2;
              end else if (v < 32'h10000) begin
                ents[0].data = {4'b1110, v[15:12]};
                ents[1].data = {2'b10, v[11:6]};
                ents[2].data = {2'b10, v[5:0]};
                n = 3'd3;
              end else begin
                ents[0].data = {5'b11110, v[20:18]};
                ents[1].data = {2'b10, v[17:12]};
                ents[2].data = {2'b10, v[11:6]};
                ents[3].data = {2'b10, v[5:0]};
                n = 3'd4;
              end
              mode_next = M_BODY;
            end
          end
        end else begin
          if (first_error_next == ST_OK) first_error_next = ST_HEX_DIG;
          mode_next = M_DONE;
        end
      end
      M_DONE: ;
      default: ;
    endcase

    // plain body byte, also the byte that ended an octal or hex run
    if (do_body && (mode_next == M_BODY)) begin
      if (char_byte == 8'h22) begin
        mode_next = M_DONE;
      end else if (char_byte == 8'h5c) begin
        mode_next = M_ESC;
      end else begin
        ents[n[IDX_W-1:0]].data = char_byte; n = n + 1'b1;
      end
    end

    if (token_end) begin
      // close a pending digit run
      if (mode_next == M_OCT) begin
        if (digit_value_next <= 32'd255) begin
          ents[n[IDX_W-1:0]].data = digit_value_next[7:0]; n = n + 1'b1;
          mode_next = M_BODY;
        end else begin
          if (first_error_next == ST_OK) first_error_next = ST_OCT_RANGE;
          mode_next = M_DONE;
        end
      end else if (mode_next == M_HEX) begin
        if (digit_count_next == 4'd0) begin
          if (first_error_next == ST_OK) first_error_next = ST_HEX_DIG;
          mode_next = M_DONE;
        end else if (value_overflow_next) begin
          if (first_error_next == ST_OK) first_error_next = ST_HEX_RANGE;
          mode_next = M_DONE;
        end else begin
          ents[n[IDX_W-1:0]].data = digit_value_next[7:0]; n = n + 1'b1;
          mode_next = M_BODY;
        end
      end else if ((mode_next == M_U4) || (mode_next == M_U8)) begin
        if (first_error_next == ST_OK) first_error_next = ST_HEX_DIG;
        mode_next = M_DONE;
      end
      if (mode_next != M_DONE) begin
        if (first_error_next == ST_OK) first_error_next = ST_END_QUOTE;
      end
      ents[n[IDX_W-1:0]].is_status = 1'b1;
      ents[n[IDX_W-1:0]].code      = first_error_next;
      n = n + 1'b1;
      // back to the reset state for the next token
      mode_next           = M_OPEN;
      digit_value_next    = '0;
      digit_count_next    = '0;
      value_overflow_next = 1'b0;
      first_error_next    = ST_OK;
    end

    res.ents = ents;
    res.cnt  = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_OPEN;
      digit_value    <= '0;
      digit_count    <= '0;
      value_overflow <= 1'b0;
      first_error    <= ST_OK;
    end else if (step) begin
      mode           <= mode_next;
      digit_value    <= digit_value_next;
      digit_count    <= digit_count_next;
      value_overflow <= value_overflow_next;
      first_error    <= first_error_next;
    end
  end

endmodule

>>> src/scd_result_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_result_buf
// holds the results of one byte and hands them out one per cycle while ready
// ----------------------------------------------------------------------------
module scd_result_buf
  import scd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_set_t    set,
  output logic        free,
  scd_out_if.source   result
);

  res_ent_t [MAX_RES-1:0] ents;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       idx;
  logic                   at_last;
  logic                   fire;

  assign at_last = ({{(CNT_W-IDX_W){1'b0}}, idx} == (cnt - 1'b1));
  assign fire    = result.valid && result.ready;
  assign free    = (cnt == '0) || (fire && at_last);

  assign result.valid       = (cnt != '0);
  assign result.out_byte    = ents[idx].data;
  assign result.is_status   = ents[idx].is_status;
  assign result.status_code = ents[idx].code;
  assign result.last        = at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= set.ents;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= set.cnt;
      idx <= '0;
    end else if (fire) begin
      if (at_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RES))
    else $error("result count beyond buffer depth");
  a_idx_in_set: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ({{(CNT_W-IDX_W){1'b0}}, idx} < cnt))
    else $error("result index outside loaded set");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    fire && !at_last && !load |=> result.valid)
    else $error("result set dropped before its last entry");
`endif

endmodule

>>> tb/scd_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_token_checker
// predicts the decoded bytes and status of each token byte request and
// compares them with the result channel, in order
// ----------------------------------------------------------------------------
module scd_token_checker
  import scd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  scd_in_if    tok,
  scd_out_if   res,
  output int   fails,
  output int   pending
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    status_t    code;
    logic       last;
  } dec_res_t;

  // decoder state
  mode_t       mode;
  logic [31:0] acc;
  logic [3:0]  ndig;
  logic        sat;
  status_t     err;

  dec_res_t byte_res_q[$];
  dec_res_t decoded_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic clear_state();
    mode = M_OPEN;
    acc  = '0;
    ndig = '0;
    sat  = 1'b0;
    err  = ST_OK;
  endtask

  task automatic emit_byte(input logic [7:0] b);
    dec_res_t r;
    r = '{data: b, is_status: 1'b0, code: ST_OK, last: 1'b0};
    byte_res_q.insert(byte_res_q.size(), r);
  endtask

  // only the first error is kept; parsing stops either way
  task automatic set_error(input status_t code);
    if (err == ST_OK) err = code;
    mode = M_DONE;
  endtask

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic start_run(input mode_t m, input logic [31:0] v, input logic [3:0] n);
    mode = m;
    acc  = v;
    ndig = n;
    sat  = 1'b0;
  endtask

  task automatic close_octal();
    if (acc <= 32'd255) begin
      emit_byte(acc[7:0]);
      mode = M_BODY;
    end else begin
      set_error(ST_OCT_RANGE);
    end
  endtask

  task automatic close_hex();
    if (ndig == 4'd0) begin
      set_error(ST_HEX_DIG);
    end else if (sat) begin
      set_error(ST_HEX_RANGE);
    end else begin
      emit_byte(acc[7:0]);
      mode = M_BODY;
    end
  endtask

  // range check, then utf-8
  task automatic close_unicode();
    logic [31:0] v;
    v = acc;
    if (v > 32'h7FFF_FFFF) begin
      set_error(ST_HEX_RANGE);
    end else if (!(v < 32'hD800 || (v > 32'hDFFF && v < 32'h11_0000))) begin
      set_error(ST_UNI_RANGE);
    end else begin
      if (v < 32'h80) begin
        emit_byte(v[7:0]);
      end else if (v < 32'h800) begin
        emit_byte(8'hC0 | v[10:6]);
        emit_byte(8'h80 | v[5:0]);
      end else if (v < 32'h1_0000) begin
        emit_byte(8'hE0 | v[15:12]);
        emit_byte(8'h80 | v[11:6]);
        emit_byte(8'h80 | v[5:0]);
      end else begin
        emit_byte(8'hF0 | v[20:18]);
        emit_byte(8'h80 | v[17:12]);
        emit_byte(8'h80 | v[11:6]);
        emit_byte(8'h80 | v[5:0]);
      end
      mode = M_BODY;
    end
  endtask

  task automatic body_char(input logic [7:0] c);
    if (c == CH_QUOTE) mode = M_DONE;
    else if (c == CH_BSLASH) mode = M_ESC;
    else emit_byte(c);
  endtask

  task automatic escape_char(input logic [7:0] c);
    mode = M_BODY;
    if (c >= "0" && c <= "7") begin
      start_run(M_OCT, 32'(c - "0"), 4'd1);
    end else begin
      case (c)
        CH_QUOTE, CH_APOS, CH_BSLASH: emit_byte(c);
        "a": emit_byte(8'h07);
        "b": emit_byte(8'h08);
        "f": emit_byte(8'h0C);
        "n": emit_byte(8'h0A);
        "r": emit_byte(8'h0D);
        "t": emit_byte(8'h09);
        "v": emit_byte(8'h0B);
        "x": start_run(M_HEX, '0, '0);
        "u": start_run(M_U4, '0, '0);
        "U": start_run(M_U8, '0, '0);
        default: set_error(ST_BAD_ESC);
      endcase
    end
  endtask

  task automatic decode_char(input logic [7:0] c);
    int h;
    h = hex_value(c);
    case (mode)
      M_OPEN: mode = M_BODY;
      M_BODY: body_char(c);
      M_ESC:  escape_char(c);
      M_OCT: begin
        if (c >= "0" && c <= "7") begin
          acc  = acc * 32'd8 + 32'(c - "0");
          ndig = ndig + 4'd1;
          if (ndig >= 4'd3) close_octal();
        end else begin
          close_octal();
          if (mode == M_BODY) body_char(c);
        end
      end
      M_HEX: begin
        if (h >= 0) begin
          acc = acc * 32'd16 + 32'(h);
          if (acc > 32'd255) begin
            sat = 1'b1;
            acc = 32'd256;
          end
          if (ndig < 4'd15) ndig = ndig + 4'd1;
        end else begin
          close_hex();
          if (mode == M_BODY) body_char(c);
        end
      end
      M_U4, M_U8: begin
        if (h >= 0) begin
          acc  = {acc[27:0], 4'(h)};
          ndig = ndig + 4'd1;
          if (ndig >= ((mode == M_U4) ? 4'd4 : 4'd8)) close_unicode();
        end else begin
          set_error(ST_HEX_DIG);
        end
      end
      default: ;
    endcase
  endtask

  task automatic close_token();
    dec_res_t r;
    if (mode == M_OCT) close_octal();
    else if (mode == M_HEX) close_hex();
    else if (mode == M_U4 || mode == M_U8) set_error(ST_HEX_DIG);
    if (mode != M_DONE) set_error(ST_END_QUOTE);
    r = '{data: 8'h00, is_status: 1'b1, code: err, last: 1'b0};
    byte_res_q.insert(byte_res_q.size(), r);
  endtask

  task automatic predict_results(input logic [7:0] c, input logic fin);
    byte_res_q.delete();
    decode_char(c);
    if (fin) begin
      close_token();
      clear_state();
    end
    if (byte_res_q.size() > 0) byte_res_q[byte_res_q.size() - 1].last = 1'b1;
    foreach (byte_res_q[i]) decoded_q.insert(decoded_q.size(), byte_res_q[i]);
  endtask

  task automatic check_result();
    dec_res_t got, want;
    got = '{data: res.out_byte, is_status: res.is_status,
            code: status_t'(res.status_code), last: res.last};
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h st=%0b code=%0d last=%0b",
                                got.data, got.is_status, got.code, got.last));
    end else begin
      want = decoded_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf(
          "got byte=%02h st=%0b code=%0d last=%0b, want byte=%02h st=%0b code=%0d last=%0b",
          got.data, got.is_status, got.code, got.last,
          want.data, want.is_status, want.code, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (res.valid && res.ready) check_result();
      if (tok.valid && tok.ready) predict_results(tok.char_byte, tok.token_end);
    end
    pending <= decoded_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// string escape decoder regression: short directed tokens, then random
// quoted tokens built mostly from well-formed escapes, under three idling
// patterns on the token and result channels
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int RANDOM_BYTES = 105;
  localparam int DRAIN_CYCLES = 20;      // margin after the last expected result

  typedef struct packed {
    logic [7:0] c;
    logic       fin;
  } tok_byte_t;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   cycles;
  int   src_idle;   // percent of cycles the sender holds back
  int   snk_stall;  // percent of cycles the receiver holds back

  tok_byte_t stim_q[$];

  scd_in_if  tok();
  scd_out_if res();

  string_literal_escape_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .token  (tok),
    .result (res)
  );

  scd_token_checker chk (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok),
    .res     (res),
    .fails   (fails),
    .pending (pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random backpressure, rate set by the current phase
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // every byte goes in with token_end low; the token builder raises it on
  // the final byte once the token is complete
  task automatic push_char(input logic [7:0] c);
    tok_byte_t b;
    b = '{c: c, fin: 1'b0};
    stim_q.insert(stim_q.size(), b);
  endtask

  task automatic end_token();
    stim_q[stim_q.size() - 1].fin = 1'b1;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    end_token();
  endtask

  // hex digit with random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return "0" + d;
    return ($urandom_range(1) ? "a" : "A") + d - 8'd10;
  endfunction

  task automatic add_hex(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) push_char(hex_char(v[i*4 +: 4]));
  endtask

  // code point for \u (16 bits) or \U (32 bits); mostly legal, with
  // surrogates and out-of-range values mixed in
  function automatic logic [31:0] pick_code_point(input logic wide);
    int k;
    k = $urandom_range(wide ? 9 : 7);
    case (k)
      0, 1:    return $urandom_range(32'h7F);
      2, 3:    return $urandom_range(32'h7FF, 32'h80);
      4:       return $urandom_range(32'hD7FF, 32'h800);
      5:       return $urandom_range(32'hFFFF, 32'hE000);
      6:       return $urandom_range(32'hDFFF, 32'hD800);
      7:       return wide ? $urandom_range(32'h10_FFFF, 32'h1_0000)
                           : $urandom_range(32'hFFFF);
      8:       return $urandom_range(32'h10_FFFF, 32'h1_0000);
      default: return $urandom;
    endcase
  endfunction

  // one body element: plain text, raw byte, or an escape of some kind
  task automatic add_element();
    string      simple;
    string      bad;
    int         k;
    int         n;
    logic [7:0] ch;
    simple = "\"'\\abfnrtv";
    bad    = "qz89cdeg?";
    k = $urandom_range(99);
    if (k < 30) begin
      // printable text, no quote and no backslash
      ch = 8'($urandom_range(8'h7E, 8'h20));
      if (ch == 8'h22 || ch == 8'h5C) ch = "A";
      push_char(ch);
    end else if (k < 38) begin
      push_char(8'($urandom_range(255)));
    end else if (k < 55) begin
      push_char("\\");
      push_char(simple[$urandom_range(simple.len() - 1)]);
    end else if (k < 65) begin
      // octal, usually in range; a leading 4..7 on three digits overflows
      push_char("\\");
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push_char(8'("0" + ((i == 0 && n == 3 && $urandom_range(3) != 0)
                            ? $urandom_range(3) : $urandom_range(7))));
    end else if (k < 75) begin
      push_char("\\");
      push_char("x");
      add_hex($urandom, $urandom_range(0, 3));
    end else if (k < 85) begin
      push_char("\\");
      push_char("u");
      add_hex(pick_code_point(1'b0), 4);
    end else if (k < 95) begin
      push_char("\\");
      push_char("U");
      add_hex(pick_code_point(1'b1), 8);
    end else if (k < 98) begin
      push_char("\\");
      push_char(bad[$urandom_range(bad.len() - 1)]);
    end else begin
      // short unicode run cut off by a non-digit
      push_char("\\");
      push_char($urandom_range(1) ? "u" : "U");
      add_hex($urandom, $urandom_range(0, 3));
      push_char("g");
    end
  endtask

  task automatic add_random_token();
    int n;
    int k;
    // the opening byte is not checked, so now and then it is anything
    push_char($urandom_range(9) == 0 ? 8'($urandom_range(255)) : 8'h22);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) add_element();
    k = $urandom_range(9);
    if (k < 8) begin
      push_char("\"");
      if (k == 7) begin
        // junk after the closing quote is ignored
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)));
      end
    end else if (k == 9) begin
      push_char("\\");
    end
    end_token();
  endtask

  task automatic build_stimulus();
    int base;
    // directed: error codes, utf-8 extremes, run termination, byte extremes
    add_text("\"");                // opening byte alone
    add_text("\"\\q\"");           // unknown escape letter
    add_text("\"\\x\"");           // \x with no digits
    add_text("\"\\x1FF");          // hex overflow, token ends in the run
    add_text("\"\\777");           // octal above 255
    add_text("\"\\uD800\"");       // surrogate
    add_text("\"\\U0010FFFF\"");   // largest code point, four utf-8 bytes
    add_text("\"\\u12\"");         // short \u run
    add_text("\"\\1a\"x");         // octal run ended by a letter, junk after
    push_char("\"");
    push_char(8'h00);
    push_char(8'hFF);
    end_token();                   // token ends inside the body
    base = stim_q.size();
    while (stim_q.size() - base < RANDOM_BYTES) add_random_token();
  endtask

  task automatic send_byte(input tok_byte_t b);
    while ($urandom_range(99) < src_idle) begin
      tok.valid <= 1'b0;
      @(posedge clk);
    end
    tok.valid     <= 1'b1;
    tok.char_byte <= b.c;
    tok.token_end <= b.fin;
    // hold until the request is taken
    do @(posedge clk); while (tok.ready !== 1'b1);
  endtask

  initial begin
    int third;
    tok.valid     <= 1'b0;
    tok.char_byte <= 8'h00;
    tok.token_end <= 1'b0;
    rst           <= 1'b1;
    src_idle  = 0;
    snk_stall = 0;
    build_stimulus();
    third = stim_q.size() / 3;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // three phases: slow sender with slower receiver, the reverse, then full rate
    foreach (stim_q[i]) begin
      if (i < third) begin
        src_idle  = 37;
        snk_stall = 72;
      end else if (i < 2 * third) begin
        src_idle  = 72;
        snk_stall = 37;
      end else begin
        src_idle  = 0;
        snk_stall = 0;
      end
      send_byte(stim_q[i]);
    end
    tok.valid <= 1'b0;

    // the last request always ends a token, so at least a status is owed
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
